@@ rtl/core/swm_pkg.sv @@
// Shared constants and types for the sliding-window median filter.
`default_nettype none

package swm_pkg;

    localparam int MAX_WINDOW  = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_BITS    = 5;
    localparam int OUT_BITS    = SAMPLE_BITS + 1;
    localparam int AGE_BITS    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FILL_BITS   = $clog2(MAX_WINDOW + 1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // One window entry: the sample and how many samples have arrived since it.
    typedef struct packed {
        sample_t               value;
        logic [AGE_BITS-1:0]   age;
    } entry_t;

    // Control broadcast from the top level to every cell of the chain.
    typedef struct packed {
        logic                  load;
        logic                  insert;
        logic                  remove;
        logic [AGE_BITS-1:0]   oldest_age;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/swm_cell.sv @@
// One cell of the sorted window chain: holds one entry and shifts with its neighbors.
`default_nettype none

module swm_cell (
    input  logic                clk,
    input  swm_pkg::cell_ctrl_t ctrl,
    input  swm_pkg::sample_t    sample,
    input  logic                valid,
    input  logic                left_le,
    input  swm_pkg::entry_t     left_entry,
    input  swm_pkg::entry_t     right_shift,
    input  logic                seen_in,
    output swm_pkg::entry_t     entry,
    output logic                le,
    output swm_pkg::entry_t     shift,
    output logic                seen_out
);
    import swm_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    entry_t post;
    logic   oldest;

    // The window is sorted, so the cells that hold values not above the new
    // sample form a prefix and the new sample lands right after it.
    assign le = valid && (entry_reg.value <= sample);

    always_comb
    begin
        if (!ctrl.insert)
        begin
            post = entry_reg;
        end
        else if (le)
        begin
            post.value = entry_reg.value;
            post.age   = entry_reg.age + AGE_BITS'(1);
        end
        else if (left_le)
        begin
            post.value = sample;
            post.age   = '0;
        end
        else
        begin
            post.value = left_entry.value;
            post.age   = left_entry.age + AGE_BITS'(1);
        end
    end

    assign oldest   = (post.age == ctrl.oldest_age);
    assign seen_out = seen_in || oldest;
    assign shift    = post;

    // When an entry is dropped, every cell at and past the oldest entry pulls from its right neighbor.
    always_comb
    begin
        if (!ctrl.load)
        begin
            entry_next = entry_reg;
        end
        else if (ctrl.remove && seen_out)
        begin
            entry_next = right_shift;
        end
        else
        begin
            entry_next = post;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

@@ rtl/core/sliding_window_median.sv @@
// Top level of the sliding-window median filter: control, cell chain and result register.
// The result is registered: it is shown in the cycle after the sample transfer that completes the window.
// Throughput: one sample per cycle while sample_stall is low, set by the insert and drop in the cell chain.
// After the window size is lowered, the excess samples are trimmed from the window one at a
// time, with sample_stall high, before the next sample is taken.
// Reset clears the fill count, the result valid flag and sets the window size to one;
// the cells are not cleared, since only entries below the fill count are ever used.
`default_nettype none

module sliding_window_median (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   window_size_we,
    input  logic [swm_pkg::CFG_BITS-1:0]           window_size,
    input  logic                                   sample_valid,
    output logic                                   sample_stall,
    input  logic signed [swm_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                   restart,
    output logic                                   median_valid,
    input  logic                                   median_stall,
    output logic signed [swm_pkg::OUT_BITS-1:0]    median_doubled
);
    import swm_pkg::*;

    // Configuration register.
    logic [CFG_BITS-1:0]  window_size_reg;
    logic [CFG_BITS-1:0]  window_size_next;

    // Number of valid entries held in the chain, always below the window size
    // whenever a sample is taken.
    logic [FILL_BITS-1:0] fill_reg;
    logic [FILL_BITS-1:0] fill_next;

    // Result register that decouples the two channels.
    logic                        median_valid_reg;
    logic                        median_valid_next;
    logic signed [OUT_BITS-1:0]  median_doubled_reg;
    logic signed [OUT_BITS-1:0]  median_doubled_next;

    logic [FILL_BITS-1:0] w_act;
    logic [FILL_BITS-1:0] fill_eff;
    logic [FILL_BITS-1:0] hi_idx;
    logic [FILL_BITS-1:0] lo_idx;
    logic                 trim_go;
    logic                 accept;
    logic                 produce;
    cell_ctrl_t           ctrl;

    entry_t               stored_vec [MAX_WINDOW];
    entry_t               left_vec   [MAX_WINDOW];
    entry_t               shift_vec  [MAX_WINDOW+1];
    logic                 le_vec     [MAX_WINDOW];
    logic                 left_le_vec[MAX_WINDOW];
    logic                 valid_vec  [MAX_WINDOW];
    logic                 seen_in_vec[MAX_WINDOW];
    logic                 seen_vec   [MAX_WINDOW];

    sample_t                     lo_val;
    sample_t                     hi_val;
    logic signed [OUT_BITS-1:0]  med_sum;

    // A window size of zero acts as one and sizes past the chain length act
    // as the full chain.
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            w_act = FILL_BITS'(1);
        end
        else if (int'(window_size_reg) > MAX_WINDOW)
        begin
            w_act = FILL_BITS'(MAX_WINDOW);
        end
        else
        begin
            w_act = FILL_BITS'(window_size_reg);
        end
    end

    // The two middle positions of a full window; for an odd size they coincide.
    assign hi_idx = w_act >> 1;
    assign lo_idx = (w_act - FILL_BITS'(1)) >> 1;

    // When the window size was lowered the chain may hold too many samples.
    // The oldest ones are then dropped one per cycle before a sample is taken,
    // which leaves the same window as dropping them after the insertion.
    assign trim_go      = (fill_reg >= w_act);
    assign sample_stall = trim_go || (median_valid_reg && median_stall);
    assign accept       = sample_valid && !sample_stall;

    // A restart empties the window before its own sample goes in.
    assign fill_eff = (sample_valid && restart) ? '0 : fill_reg;
    assign produce  = ((fill_eff + FILL_BITS'(1)) == w_act);

    // On insertion the oldest entry carries the age equal to the old fill count;
    // while trimming it carries the fill count less one.
    always_comb
    begin
        ctrl.load   = accept || trim_go;
        ctrl.insert = accept;
        ctrl.remove = trim_go || (accept && produce);
        if (accept)
        begin
            ctrl.oldest_age = AGE_BITS'(fill_eff);
        end
        else
        begin
            ctrl.oldest_age = AGE_BITS'(fill_reg - FILL_BITS'(1));
        end
    end

    assign shift_vec[MAX_WINDOW] = '0;

    for (genvar k = 0; k < MAX_WINDOW; k++)
    begin : g_cell
        assign valid_vec[k] = (FILL_BITS'(k) < fill_eff);

        if (k == 0)
        begin : g_head
            assign left_vec[k]    = '0;
            assign left_le_vec[k] = 1'b1;
            assign seen_in_vec[k] = 1'b0;
        end
        else
        begin : g_body
            assign left_vec[k]    = stored_vec[k-1];
            assign left_le_vec[k] = le_vec[k-1];
            assign seen_in_vec[k] = seen_vec[k-1];
        end

        swm_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .sample      (sample),
            .valid       (valid_vec[k]),
            .left_le     (left_le_vec[k]),
            .left_entry  (left_vec[k]),
            .right_shift (shift_vec[k+1]),
            .seen_in     (seen_in_vec[k]),
            .entry       (stored_vec[k]),
            .le          (le_vec[k]),
            .shift       (shift_vec[k]),
            .seen_out    (seen_vec[k])
        );
    end

    // Pick the two middle values of the window as it stands after the
    // insertion, before the oldest sample leaves.
    always_comb
    begin
        lo_val = '0;
        hi_val = '0;
        for (int k = 0; k < MAX_WINDOW; k++)
        begin
            if (FILL_BITS'(k) == lo_idx)
            begin
                lo_val = lo_val | shift_vec[k].value;
            end
            if (FILL_BITS'(k) == hi_idx)
            begin
                hi_val = hi_val | shift_vec[k].value;
            end
        end
    end

    // The sum of two samples always fits one extra bit.
    assign med_sum = OUT_BITS'(lo_val) + OUT_BITS'(hi_val);

    always_comb
    begin
        window_size_next = window_size_we ? window_size : window_size_reg;

        if (accept)
        begin
            fill_next = produce ? fill_eff : (fill_eff + FILL_BITS'(1));
        end
        else if (trim_go)
        begin
            fill_next = fill_reg - FILL_BITS'(1);
        end
        else
        begin
            fill_next = fill_reg;
        end

        median_valid_next   = (accept && produce) || (median_valid_reg && median_stall);
        median_doubled_next = (accept && produce) ? med_sum : median_doubled_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg  <= CFG_BITS'(1);
            fill_reg         <= '0;
            median_valid_reg <= 1'b0;
        end
        else
        begin
            window_size_reg  <= window_size_next;
            fill_reg         <= fill_next;
            median_valid_reg <= median_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        median_doubled_reg <= median_doubled_next;
    end

    assign median_valid   = median_valid_reg;
    assign median_doubled = median_doubled_reg;

    // Every drop must find the oldest entry somewhere in the chain.
    a_remove_finds_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.remove |-> seen_vec[MAX_WINDOW-1])
        else $error("no oldest entry found while dropping");

    // The chain never holds a full set of entries between transfers.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < FILL_BITS'(MAX_WINDOW))
        else $error("fill count out of range");

    // A sample is only taken once any excess entries have been trimmed.
    a_accept_fits: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (fill_reg < w_act))
        else $error("sample taken with an untrimmed window");

    // After a result the window holds one sample less than its size.
    a_fill_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && produce) |=> (fill_reg == ($past(w_act) - FILL_BITS'(1))))
        else $error("fill count wrong after a result");

endmodule

`default_nettype wire
